// File: rtl/core/clnws_pkg.sv
// ----------------------------------------------------------------------------
// clnws_pkg
// Shared types, codes and constants for the character display nibble
// write sequencer.
// ----------------------------------------------------------------------------
package clnws_pkg;

    // Request operation codes
    localparam logic [1:0] OpPutChar = 2'd0;
    localparam logic [1:0] OpGoto    = 2'd1;
    localparam logic [1:0] OpNumber  = 2'd2;

    // Configuration register indexes
    localparam int CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] CfgExecDelay  = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgClearDelay = 2'd1;
    localparam int CfgDataW = 16;

    localparam logic [9:0]  ExecDelayReset  = 10'd50;
    localparam logic [15:0] ClearDelayReset = 16'd1600;

    // Special characters
    localparam logic [7:0] ChFormFeed  = 8'h0C;
    localparam logic [7:0] ChNewline   = 8'h0A;
    localparam logic [7:0] ChBackspace = 8'h08;
    localparam logic [7:0] ChDigitZero = 8'h30;

    // Display commands
    localparam logic [7:0] CmdClear = 8'h01;
    localparam logic [7:0] CmdShift = 8'h10;
    localparam logic [7:0] CmdDdram = 8'h80;
    localparam logic [7:0] Row2Base = 8'h40;
    localparam logic [7:0] RowOne   = 8'd1;
    localparam logic [7:0] RowTwo   = 8'd2;

    // Decimal conversion
    localparam int Pow0 = 10000;
    localparam int Pow1 = 1000;
    localparam int Pow2 = 100;
    localparam int Pow3 = 10;
    localparam logic [2:0] DigitLastStep = 3'd4;

    localparam int QueueDepth = 4;

    typedef enum logic {
        FrontIdle,
        FrontDigits
    } t_front_state;

    // One display byte waiting to be sent as two nibbles
    typedef struct packed {
        logic [7:0] byte_val;
        logic       rs;
        logic       bad_row;
        logic       clear;
        logic       last;
    } t_byte_job;

    typedef struct packed {
        logic [3:0]  digit;
        logic [16:0] sub;
    } t_digit;

    // Quotient and subtrahend of rest by a constant power of ten
    function automatic t_digit divmod_const(logic [15:0] rest, int pow);
        t_digit     r;
        logic [16:0] thr;
        r.digit = 4'd0;
        r.sub   = 17'd0;
        for (int k = 1; k <= 9; k++) begin
            thr = 17'(k * pow);
            if ({1'b0, rest} >= thr) begin
                r.digit = 4'(k);
                r.sub   = thr;
            end
        end
        return r;
    endfunction

    function automatic t_byte_job goto_job(logic [7:0] col, logic [7:0] row);
        t_byte_job  j;
        logic [7:0] base;
        j = '0;
        base = 8'd0;
        if (col != 8'd0 && row != 8'd0) begin
            if (row == RowTwo) begin
                base = Row2Base;
            end else if (row != RowOne) begin
                j.bad_row = 1'b1;
            end
            j.byte_val = (base + col - 8'd1) | CmdDdram;
        end
        j.last = 1'b1;
        return j;
    endfunction

endpackage

// File: rtl/core/clnws_if.sv
// ----------------------------------------------------------------------------
// clnws interfaces
// Request, result and configuration channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface clnws_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [7:0]  char_code;
    logic [7:0]  column;
    logic [7:0]  row;
    logic [15:0] number;

    modport source (output valid, operation, char_code, column, row, number, input ready);
    modport sink   (input valid, operation, char_code, column, row, number, output ready);
endinterface

interface clnws_res_if;
    logic        valid;
    logic        ready;
    logic [3:0]  nibble;
    logic        register_select;
    logic [9:0]  wait_before_us;
    logic [16:0] wait_after_us;
    logic        bad_row;
    logic        last;

    modport source (output valid, nibble, register_select, wait_before_us, wait_after_us,
                    bad_row, last, input ready);
    modport sink   (input valid, nibble, register_select, wait_before_us, wait_after_us,
                    bad_row, last, output ready);
endinterface

interface clnws_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [clnws_pkg::CfgIdxW-1:0] index;
    logic [clnws_pkg::CfgDataW-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/char_lcd_nibble_write_sequencer_unit.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer_unit
// Character display 4-bit write sequencer: requests in, nibble words out.
// ----------------------------------------------------------------------------
// Timing: a character or move request passes through the byte queue and
//   the output register before its first nibble word is valid. The back
//   end gives one nibble word per cycle while the sink is ready; the digit
//   splitter holds the front end after it takes a number, until its last
//   digit byte has gone into the queue.
// Reset: synchronous, active low; queue and output empty, exec delay 50 us,
//   clear delay 1600 us.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer_unit #(
    parameter int QDepth = clnws_pkg::QueueDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    clnws_req_if.sink   i_req,
    clnws_cfg_if.sink   i_cfg,
    clnws_res_if.source o_res
);

    // Timing registers. The user must write them only while idle; the block
    // does not enforce it, and the back end reads them live.
    logic [9:0]  r_exec_delay;
    logic [15:0] r_clear_delay;

    // Front to queue, queue to back
    logic                 push, pop, q_full, q_empty;
    clnws_pkg::t_byte_job push_job, head_job;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exec_delay  <= clnws_pkg::ExecDelayReset;
            r_clear_delay <= clnws_pkg::ClearDelayReset;
        end else if (i_cfg.valid) begin
            // indexes past the list are ignored
            if (i_cfg.index == clnws_pkg::CfgExecDelay) begin
                r_exec_delay <= i_cfg.data[9:0];
            end else if (i_cfg.index == clnws_pkg::CfgClearDelay) begin
                r_clear_delay <= i_cfg.data;
            end
        end
    end

    // Front: decode request, split numbers into digits
    clnws_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (push_job)
    );

    // Byte job queue decouples decoding from the nibble stream
    clnws_queue #(
        .QDepth (QDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_job)
    );

    // Back: high nibble then low nibble per byte, registered output
    clnws_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (q_empty),
        .i_head        (head_job),
        .o_pop         (pop),
        .i_exec_delay  (r_exec_delay),
        .i_clear_delay (r_clear_delay),
        .o_res         (o_res)
    );

endmodule

// File: rtl/core/clnws_front.sv
// ----------------------------------------------------------------------------
// clnws_front
// Accepts requests and turns them into display byte jobs; numbers are
// split into decimal digits one per cycle while the queue has room.
// ----------------------------------------------------------------------------
module clnws_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    clnws_req_if.sink            i_req,
    input  logic                 i_q_full,
    output logic                 o_push,
    output clnws_pkg::t_byte_job o_job
);

    clnws_pkg::t_front_state r_state, n_state;
    logic [15:0] r_rest, n_rest;
    logic [2:0]  r_step, n_step;
    logic        r_started, n_started;

    clnws_pkg::t_digit    dm;
    clnws_pkg::t_byte_job job;
    logic                 want;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= clnws_pkg::FrontIdle;
            r_step    <= 3'd0;
            r_started <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_step    <= n_step;
            r_started <= n_started;
        end
        r_rest <= n_rest;
    end

    always_comb begin
        case (r_step)
            3'd0:    dm = clnws_pkg::divmod_const(r_rest, clnws_pkg::Pow0);
            3'd1:    dm = clnws_pkg::divmod_const(r_rest, clnws_pkg::Pow1);
            3'd2:    dm = clnws_pkg::divmod_const(r_rest, clnws_pkg::Pow2);
            3'd3:    dm = clnws_pkg::divmod_const(r_rest, clnws_pkg::Pow3);
            default: dm = '{digit: r_rest[3:0], sub: 17'd0};
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_rest      = r_rest;
        n_step      = r_step;
        n_started   = r_started;
        want        = 1'b0;
        job         = '0;
        i_req.ready = 1'b0;

        case (r_state)
            clnws_pkg::FrontIdle: begin
                i_req.ready = !i_q_full;
                if (i_req.valid && !i_q_full) begin
                    case (i_req.operation)
                        clnws_pkg::OpPutChar: begin
                            want = 1'b1;
                            job.last = 1'b1;
                            if (i_req.char_code == clnws_pkg::ChFormFeed) begin
                                job.byte_val = clnws_pkg::CmdClear;
                                job.clear    = 1'b1;
                            end else if (i_req.char_code == clnws_pkg::ChNewline) begin
                                job = clnws_pkg::goto_job(clnws_pkg::RowOne, clnws_pkg::RowTwo);
                            end else if (i_req.char_code == clnws_pkg::ChBackspace) begin
                                job.byte_val = clnws_pkg::CmdShift;
                            end else begin
                                job.byte_val = i_req.char_code;
                                job.rs       = 1'b1;
                            end
                        end
                        clnws_pkg::OpGoto: begin
                            want = 1'b1;
                            job  = clnws_pkg::goto_job(i_req.column, i_req.row);
                        end
                        clnws_pkg::OpNumber: begin
                            n_state   = clnws_pkg::FrontDigits;
                            n_rest    = i_req.number;
                            n_step    = 3'd0;
                            n_started = 1'b0;
                        end
                        default: ;  // unused code: dropped
                    endcase
                end
            end
            clnws_pkg::FrontDigits: begin
                job.byte_val = clnws_pkg::ChDigitZero + {4'd0, dm.digit};
                job.rs       = 1'b1;
                if (r_step == clnws_pkg::DigitLastStep) begin
                    want     = 1'b1;
                    job.last = 1'b1;
                    if (!i_q_full) begin
                        n_state = clnws_pkg::FrontIdle;
                    end
                end else begin
                    // leading zeros produce no byte
                    want = r_started || (dm.digit != 4'd0);
                    if (!want || !i_q_full) begin
                        n_rest    = r_rest - dm.sub[15:0];
                        n_step    = r_step + 3'd1;
                        n_started = want;
                    end
                end
            end
            default: n_state = clnws_pkg::FrontIdle;
        endcase
    end

    assign o_push = want && !i_q_full;
    assign o_job  = job;

endmodule

// File: rtl/core/clnws_queue.sv
// ----------------------------------------------------------------------------
// clnws_queue
// Short FIFO of byte jobs between front and back.
// ----------------------------------------------------------------------------
module clnws_queue #(
    parameter int QDepth = clnws_pkg::QueueDepth
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  clnws_pkg::t_byte_job i_job,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output clnws_pkg::t_byte_job o_head
);

    localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
    localparam int CntW = $clog2(QDepth + 1);
    localparam logic [PtrW-1:0] PtrMax = PtrW'(QDepth - 1);

    clnws_pkg::t_byte_job r_mem [QDepth];
    logic [PtrW-1:0] r_wr, r_rd;
    logic [CntW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PtrMax) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PtrMax) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    assign o_full  = (r_cnt == CntW'(QDepth));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

endmodule

// File: rtl/core/clnws_back.sv
// ----------------------------------------------------------------------------
// clnws_back
// Splits byte jobs into high and low nibble words with their wait times.
// ----------------------------------------------------------------------------
module clnws_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  clnws_pkg::t_byte_job i_head,
    output logic                 o_pop,
    input  logic [9:0]           i_exec_delay,
    input  logic [15:0]          i_clear_delay,
    clnws_res_if.source          o_res
);

    logic        r_phase;   // 0: high nibble next, 1: low nibble next
    logic        r_valid;
    logic [3:0]  r_nibble;
    logic        r_rs;
    logic [9:0]  r_wait_before;
    logic [16:0] r_wait_after;
    logic        r_bad;
    logic        r_last;
    logic        load;

    assign load  = (!r_valid || o_res.ready) && !i_empty;
    assign o_pop = load && r_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_phase <= !r_phase;
                r_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rs  <= i_head.rs;
            r_bad <= i_head.bad_row;
            if (!r_phase) begin
                r_nibble      <= i_head.byte_val[7:4];
                r_wait_before <= i_exec_delay;
                r_wait_after  <= {7'd0, i_exec_delay};
                r_last        <= 1'b0;
            end else begin
                r_nibble      <= i_head.byte_val[3:0];
                r_wait_before <= 10'd0;
                r_wait_after  <= {7'd0, i_exec_delay}
                               + (i_head.clear ? {1'b0, i_clear_delay} : 17'd0);
                r_last        <= i_head.last;
            end
        end
    end

    assign o_res.valid           = r_valid;
    assign o_res.nibble          = r_nibble;
    assign o_res.register_select = r_rs;
    assign o_res.wait_before_us  = r_wait_before;
    assign o_res.wait_after_us   = r_wait_after;
    assign o_res.bad_row         = r_bad;
    assign o_res.last            = r_last;

endmodule

// File: tb/char_lcd_nibble_write_sequencer_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer_unit_test
// Self-checking bench for the display nibble write sequencer. A short table
// of directed requests comes first, then random requests over several delay
// settings. Every nibble word is compared against a model kept in the bench.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer_unit_test;
    import clnws_pkg::*;

    // Codes the package has no name for
    localparam logic [1:0]         OpUnused      = 2'd3;
    localparam logic [CfgIdxW-1:0] CfgIdxSpareLo = 2'd2;
    localparam logic [CfgIdxW-1:0] CfgIdxSpareHi = 2'd3;

    localparam int DrainCycles   = 24;      // covers an ignored request still in flight
    localparam int HoldOffCycles = 300;     // long sink stall, fills the request queue
    localparam int CycleLimit    = 400000;
    localparam int RandPhases    = 6;
    localparam int PhaseItems    = 78;

    typedef enum int {
        SinkAlways,
        SinkRandom,
        SinkPattern
    } sink_mode_t;

    typedef enum logic [1:0] {
        UsePredictor,
        ExpectNothing,
        ExpectByte
    } check_kind_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  char_code;
        logic [7:0]  column;
        logic [7:0]  row;
        logic [15:0] number;
    } lcd_request_t;

    // One transfer on the 4-bit display bus
    typedef struct packed {
        logic [3:0]  nibble;
        logic        register_select;
        logic [9:0]  wait_before_us;
        logic [16:0] wait_after_us;
        logic        bad_row;
        logic        last;
    } nibble_word_t;

    // Directed row: a request plus, where it is obvious, the single byte it sends
    typedef struct packed {
        lcd_request_t req;
        check_kind_t  kind;
        logic [7:0]   gold_byte;
        logic         gold_rs;
        logic         gold_bad_row;
        logic         gold_clear;
    } directed_row_t;

    localparam directed_row_t DirTab [23] = '{
        // put character: plain, specials, extremes
        '{'{OpPutChar, 8'h41, 8'd0, 8'd0, 16'd0}, UsePredictor, 8'h00, 1'b0, 1'b0, 1'b0},
        '{'{OpPutChar, ChFormFeed, 8'd0, 8'd0, 16'd0}, ExpectByte, CmdClear, 1'b0, 1'b0, 1'b1},
        '{'{OpPutChar, ChNewline, 8'd0, 8'd0, 16'd0}, ExpectByte, CmdDdram | Row2Base,
          1'b0, 1'b0, 1'b0},
        '{'{OpPutChar, ChBackspace, 8'd0, 8'd0, 16'd0}, ExpectByte, CmdShift, 1'b0, 1'b0, 1'b0},
        '{'{OpPutChar, 8'h00, 8'd0, 8'd0, 16'd0}, ExpectByte, 8'h00, 1'b1, 1'b0, 1'b0},
        '{'{OpPutChar, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF}, ExpectByte, 8'hFF, 1'b1, 1'b0, 1'b0},
        '{'{OpPutChar, 8'h0D, 8'd0, 8'd0, 16'd0}, UsePredictor, 8'h00, 1'b0, 1'b0, 1'b0},
        // move: both lines, zero column/row, rejected rows
        '{'{OpGoto, 8'd0, 8'd1, RowOne, 16'd0}, ExpectByte, CmdDdram, 1'b0, 1'b0, 1'b0},
        '{'{OpGoto, 8'd0, 8'd40, RowTwo, 16'd0}, UsePredictor, 8'h00, 1'b0, 1'b0, 1'b0},
        '{'{OpGoto, 8'd0, 8'd255, RowTwo, 16'd0}, UsePredictor, 8'h00, 1'b0, 1'b0, 1'b0},
        '{'{OpGoto, 8'd0, 8'd0, RowOne, 16'd0}, ExpectByte, 8'h00, 1'b0, 1'b0, 1'b0},
        '{'{OpGoto, 8'd0, 8'd5, 8'd0, 16'd0}, ExpectByte, 8'h00, 1'b0, 1'b0, 1'b0},
        '{'{OpGoto, 8'hFF, 8'd0, 8'd0, 16'hFFFF}, ExpectByte, 8'h00, 1'b0, 1'b0, 1'b0},
        '{'{OpGoto, 8'd0, 8'd3, 8'd3, 16'd0}, ExpectByte, 8'h82, 1'b0, 1'b1, 1'b0},
        '{'{OpGoto, 8'd0, 8'd255, 8'd255, 16'd0}, ExpectByte, 8'hFE, 1'b0, 1'b1, 1'b0},
        // number: zero, one digit, carries, extremes
        '{'{OpNumber, 8'd0, 8'd0, 8'd0, 16'd0}, ExpectByte, ChDigitZero, 1'b1, 1'b0, 1'b0},
        '{'{OpNumber, 8'd0, 8'd0, 8'd0, 16'd9}, ExpectByte, 8'h39, 1'b1, 1'b0, 1'b0},
        '{'{OpNumber, 8'd0, 8'd0, 8'd0, 16'd10}, UsePredictor, 8'h00, 1'b0, 1'b0, 1'b0},
        '{'{OpNumber, 8'd0, 8'd0, 8'd0, 16'd1005}, UsePredictor, 8'h00, 1'b0, 1'b0, 1'b0},
        '{'{OpNumber, 8'd0, 8'd0, 8'd0, 16'd10000}, UsePredictor, 8'h00, 1'b0, 1'b0, 1'b0},
        '{'{OpNumber, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF}, UsePredictor, 8'h00, 1'b0, 1'b0, 1'b0},
        // unused operation code makes no transfer
        '{'{OpUnused, 8'd0, 8'd0, 8'd0, 16'd0}, ExpectNothing, 8'h00, 1'b0, 1'b0, 1'b0},
        '{'{OpUnused, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF}, ExpectNothing, 8'h00, 1'b0, 1'b0, 1'b0}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    clnws_req_if req_bus ();
    clnws_cfg_if cfg_bus ();
    clnws_res_if res_bus ();

    char_lcd_nibble_write_sequencer_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .i_cfg   (cfg_bus),
        .o_res   (res_bus)
    );

    // Shadow of the delay registers, as the block should hold them
    logic [9:0]   exec_us;
    logic [15:0]  clear_us;

    nibble_word_t words_due [$];    // nibble words still owed by the block
    int           fail_count  = 0;
    int           cycle_count = 0;
    sink_mode_t   sink_mode   = SinkAlways;
    bit           hold_off_req = 1'b0;
    bit           gappy       = 1'b0;
    int           burst_left  = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------

    // A byte goes out high nibble first; only the high nibble carries the
    // settle time, only the low nibble the extra wait after a clear.
    function automatic void queue_byte(logic [7:0] val, logic rs, logic [15:0] extra_us,
                                       logic bad);
        nibble_word_t w;
        w.nibble          = val[7:4];
        w.register_select = rs;
        w.wait_before_us  = exec_us;
        w.wait_after_us   = 17'(exec_us);
        w.bad_row         = bad;
        w.last            = 1'b0;
        words_due.push_back(w);
        w.nibble          = val[3:0];
        w.wait_before_us  = 10'd0;
        w.wait_after_us   = 17'(exec_us) + 17'(extra_us);
        words_due.push_back(w);
    endfunction

    // Flag the final word of a request, if it made any
    function automatic void mark_last(int first_idx);
        if (words_due.size() > first_idx) begin
            words_due[words_due.size() - 1].last = 1'b1;
        end
    endfunction

    // DDRAM address command; zero column or row sends a bare 0x00
    function automatic logic [7:0] cursor_cmd(logic [7:0] col, logic [7:0] row,
                                              output logic bad);
        logic [7:0] base;
        bad  = 1'b0;
        base = 8'd0;
        if (col == 8'd0 || row == 8'd0) begin
            return 8'd0;
        end
        if (row == RowTwo) begin
            base = Row2Base;
        end else if (row != RowOne) begin
            bad = 1'b1;
        end
        return (base + col - 8'd1) | CmdDdram;
    endfunction

    function automatic void predict_words(lcd_request_t r);
        int          first_idx;
        logic        bad;
        logic [7:0]  cmd;
        int unsigned rest;
        int unsigned scale;
        int unsigned digit;
        bit          started;
        first_idx = words_due.size();
        case (r.operation)
            OpPutChar: begin
                if (r.char_code == ChFormFeed) begin
                    queue_byte(CmdClear, 1'b0, clear_us, 1'b0);
                end else if (r.char_code == ChNewline) begin
                    cmd = cursor_cmd(8'd1, RowTwo, bad);
                    queue_byte(cmd, 1'b0, 16'd0, bad);
                end else if (r.char_code == ChBackspace) begin
                    queue_byte(CmdShift, 1'b0, 16'd0, 1'b0);
                end else begin
                    queue_byte(r.char_code, 1'b1, 16'd0, 1'b0);
                end
            end
            OpGoto: begin
                cmd = cursor_cmd(r.column, r.row, bad);
                queue_byte(cmd, 1'b0, 16'd0, bad);
            end
            OpNumber: begin
                // leading zeros dropped, units digit always sent
                rest    = r.number;
                started = 1'b0;
                for (scale = 10000; scale >= 10; scale = scale / 10) begin
                    digit = rest / scale;
                    if (started || digit != 0) begin
                        queue_byte(ChDigitZero + 8'(digit), 1'b1, 16'd0, 1'b0);
                        started = 1'b1;
                    end
                    rest = rest - digit * scale;
                end
                queue_byte(ChDigitZero + 8'(rest), 1'b1, 16'd0, 1'b0);
            end
            default: ;  // unused code: nothing sent
        endcase
        mark_last(first_idx);
    endfunction

    // ---------------------------------------------------------------------
    // Random requests: mostly meaningful ones, unused fields left as noise
    // ---------------------------------------------------------------------
    function automatic lcd_request_t random_request();
        lcd_request_t r;
        int           pick;
        r.char_code = 8'($urandom);
        r.column    = 8'($urandom);
        r.row       = 8'($urandom);
        r.number    = 16'($urandom);
        pick        = $urandom_range(0, 99);
        if (pick < 40) begin
            r.operation = OpPutChar;
            case ($urandom_range(0, 7))
                0: r.char_code = ChFormFeed;
                1: r.char_code = ChNewline;
                2: r.char_code = ChBackspace;
                3, 4: r.char_code = 8'($urandom_range(32, 126));
                default: ;
            endcase
        end else if (pick < 70) begin
            r.operation = OpGoto;
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    r.column = 8'($urandom_range(1, 40));
                    r.row    = RowOne;
                end
                3, 4, 5: begin
                    r.column = 8'($urandom_range(1, 40));
                    r.row    = RowTwo;
                end
                6: r.column = 8'd0;
                7: r.row    = 8'd0;
                default: ;
            endcase
        end else if (pick < 95) begin
            r.operation = OpNumber;
            case ($urandom_range(0, 5))
                0: r.number = 16'($urandom_range(0, 9));
                1: r.number = 16'($urandom_range(0, 99));
                2: r.number = 16'($urandom_range(0, 999));
                3: r.number = 16'($urandom_range(0, 9999));
                default: ;
            endcase
        end else begin
            r.operation = OpUnused;
        end
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------------

    // Present one request and hold it until taken
    task automatic offer(lcd_request_t r);
        req_bus.operation <= r.operation;
        req_bus.char_code <= r.char_code;
        req_bus.column    <= r.column;
        req_bus.row       <= r.row;
        req_bus.number    <= r.number;
        req_bus.valid     <= 1'b1;
        do @(posedge i_clk); while (!req_bus.ready);
    endtask

    // Bursts of back-to-back requests separated by idle gaps
    task automatic pace();
        if (gappy) begin
            if (burst_left == 0) begin
                req_bus.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                burst_left = $urandom_range(1, 16);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic wait_for_drain();
        req_bus.valid <= 1'b0;
        while (words_due.size() != 0) @(posedge i_clk);
    endtask

    // Idle: nothing owed, and any ignored request has left the pipe
    task automatic settle();
        wait_for_drain();
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        cfg_bus.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_bus.ready);
        case (idx)
            CfgExecDelay:  exec_us  = val[9:0];     // upper data bits dropped
            CfgClearDelay: clear_us = val;
            default: ;
        endcase
    endtask

    // Two back-to-back register writes; valid drops only after the second
    task automatic program_delays(logic [CfgIdxW-1:0] idx_a, logic [CfgDataW-1:0] val_a,
                                  logic [CfgIdxW-1:0] idx_b, logic [CfgDataW-1:0] val_b);
        cfg_write(idx_a, val_a);
        cfg_write(idx_b, val_b);
        cfg_bus.valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------------
    // Result side: sink stall pattern, with an occasional long hold-off
    // ---------------------------------------------------------------------
    initial begin : sink_drive
        int hold_left;
        int beat;
        hold_left     = 0;
        beat          = 0;
        res_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_left    = HoldOffCycles;
                hold_off_req = 1'b0;
            end
            beat = (beat + 1) % 7;
            if (hold_left > 0) begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end else begin
                case (sink_mode)
                    SinkRandom:  res_bus.ready <= ($urandom_range(0, 9) < 6);
                    SinkPattern: res_bus.ready <= (beat < 4);
                    default:     res_bus.ready <= 1'b1;
                endcase
            end
        end
    end

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Every accepted word is matched against the oldest one owed
    always @(posedge i_clk) begin
        nibble_word_t want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (words_due.size() == 0) begin
                $error("nibble word with nothing owed: nibble %0h rs %0b last %0b",
                       res_bus.nibble, res_bus.register_select, res_bus.last);
                fail_count++;
            end else begin
                want = words_due.pop_front();
                check_field("nibble", want.nibble, res_bus.nibble);
                check_field("register_select", want.register_select, res_bus.register_select);
                check_field("wait_before_us", want.wait_before_us, res_bus.wait_before_us);
                check_field("wait_after_us", want.wait_after_us, res_bus.wait_after_us);
                check_field("bad_row", want.bad_row, res_bus.bad_row);
                check_field("last", want.last, res_bus.last);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin : stimulus
        lcd_request_t r;
        int           first_idx;
        req_bus.valid     = 1'b0;
        req_bus.operation = OpPutChar;
        req_bus.char_code = 8'd0;
        req_bus.column    = 8'd0;
        req_bus.row       = 8'd0;
        req_bus.number    = 16'd0;
        cfg_bus.valid     = 1'b0;
        cfg_bus.index     = CfgExecDelay;
        cfg_bus.data      = '0;
        exec_us           = ExecDelayReset;
        clear_us          = ClearDelayReset;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table under reset delays; sink never stalls
        gappy = 1'b1;
        foreach (DirTab[k]) begin
            offer(DirTab[k].req);
            case (DirTab[k].kind)
                ExpectByte: begin
                    first_idx = words_due.size();
                    queue_byte(DirTab[k].gold_byte, DirTab[k].gold_rs,
                               DirTab[k].gold_clear ? clear_us : 16'd0,
                               DirTab[k].gold_bad_row);
                    mark_last(first_idx);
                end
                ExpectNothing: ;
                default: predict_words(DirTab[k].req);
            endcase
            pace();
        end

        // Random phases, each under its own delay setting and traffic shape
        for (int p = 0; p < RandPhases; p++) begin
            settle();
            case (p)
                0: begin
                    // spare indexes: the registers must keep their reset values
                    program_delays(CfgIdxSpareLo, 16'($urandom), CfgIdxSpareHi, 16'($urandom));
                    sink_mode = SinkAlways;
                    gappy     = 1'b0;
                end
                1: begin
                    program_delays(CfgExecDelay, 16'd0, CfgClearDelay, 16'd0);
                    sink_mode = SinkRandom;
                    gappy     = 1'b1;
                end
                2: begin
                    // all-ones data: exec delay keeps only its 10 bits
                    program_delays(CfgExecDelay, 16'hFFFF, CfgClearDelay, 16'hFFFF);
                    sink_mode = SinkPattern;
                    gappy     = 1'b1;
                end
                3: begin
                    program_delays(CfgClearDelay, 16'($urandom), CfgExecDelay, 16'($urandom));
                    sink_mode = SinkRandom;
                    gappy     = 1'b1;
                end
                4: begin
                    program_delays(CfgExecDelay, 16'd1, CfgClearDelay, 16'd1);
                    sink_mode = SinkAlways;
                    gappy     = 1'b1;
                end
                default: begin
                    program_delays(CfgExecDelay, 16'($urandom), CfgClearDelay, 16'($urandom));
                    sink_mode = SinkPattern;
                    gappy     = 1'b0;
                end
            endcase
            burst_left = $urandom_range(1, 16);

            for (int n = 0; n < PhaseItems; n++) begin
                // odd phases: long sink hold-off while requests keep coming
                if (p % 2 == 1 && n == PhaseItems / 3) begin
                    hold_off_req = 1'b1;
                end
                // even phases: sender pauses until everything owed has come
                if (p % 2 == 0 && n == 2 * PhaseItems / 3) begin
                    wait_for_drain();
                end
                r = random_request();
                offer(r);
                predict_words(r);
                pace();
            end
        end

        settle();
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
